// ----- src/fcw_pkg.sv -----
// ============================================================================
// fcw_pkg - shared types and constants for the FAT cluster chain writer
// Holds the item structs, the configuration bundle, opcodes, status codes,
// width modes, register indexes and default sizes.
// ============================================================================
package fcw_pkg;

    // Default size of the table store in bytes.
    localparam int unsigned FCW_TABLE_BYTES = 8192;

    // Width of a byte offset into the table (four times a 28-bit cluster).
    localparam int unsigned OFF_W = 30;

    // Opcodes of an input item.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_CONT  = 3'd1;
    localparam logic [2:0] OP_END   = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Entry width modes; any mode with the upper bit set is 32-bit.
    localparam logic [1:0] MODE_12 = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_MEDIA = 2'd2;

    // Reset values of the registers.
    localparam logic [1:0]  MODE_RST  = 2'd0;
    localparam logic [27:0] COUNT_RST = 28'd4085;
    localparam logic [7:0]  MEDIA_RST = 8'hF0;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [12:0] byte_address;
    } t_in_item;

    typedef struct packed {
        logic [27:0] cluster_number;
        logic [7:0]  read_data;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  entry_width_mode;
        logic [27:0] cluster_count;
        logic [7:0]  media_byte;
    } t_cfg;

endpackage

// ----- src/fcw_ram.sv -----
// ============================================================================
// fcw_ram - generic single-port-write, single-port-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module fcw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/fcw_regs.sv -----
// ============================================================================
// fcw_regs - configuration registers behind the APB-style port
// Holds entry width mode, cluster count and media byte; reads return them.
// ============================================================================
module fcw_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output fcw_pkg::t_cfg o_cfg
);

    import fcw_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_width_mode <= MODE_RST;
            r_cfg.cluster_count    <= COUNT_RST;
            r_cfg.media_byte       <= MEDIA_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE:  r_cfg.entry_width_mode <= pwdata[1:0];
                REG_COUNT: r_cfg.cluster_count    <= pwdata[27:0];
                REG_MEDIA: r_cfg.media_byte       <= pwdata[7:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE:  prdata = 32'(r_cfg.entry_width_mode);
            REG_COUNT: prdata = 32'(r_cfg.cluster_count);
            REG_MEDIA: prdata = 32'(r_cfg.media_byte);
            default:   prdata = 32'd0;
        endcase
    end

endmodule

// ----- src/fcw_seq.sv -----
// ============================================================================
// fcw_seq - request sequencer for the FAT cluster chain writer
// Decodes each item, keeps the cluster counter and drives the table RAM
// through clearing sweeps, byte reads and entry writes, twelve-bit by RMW.
// ============================================================================
module fcw_seq #(
    parameter int unsigned TABLE_BYTES = fcw_pkg::FCW_TABLE_BYTES,
    parameter int unsigned AW          = $clog2(TABLE_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcw_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fcw_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fcw_pkg::t_out_item o_out_item,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [7:0]         o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [7:0]         i_mem_rdata
);

    import fcw_pkg::*;

    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_BYTES - 1);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_CALC   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_RDWAIT = 8'b0001_0000,
        S_MERGE  = 8'b0010_0000,
        S_WRITE  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state         r_state, n_state;
    logic [27:0]    r_cur, n_cur;
    logic [AW-1:0]  r_clr, n_clr;
    logic           r_init, n_init;
    logic [1:0]     r_bidx, n_bidx;
    logic           r_out_valid, n_out_valid;
    t_out_item      r_res, n_res;
    t_out_item      r_out, n_out;

    logic [2:0]     r_op;
    logic [12:0]    r_addr;
    logic [OFF_W-1:0] r_off;
    logic           r_full;
    logic           r_odd;
    logic [7:0]     r_old;

    logic [OFF_W-1:0] w_off;
    logic [27:0]    w_cur_inc;
    logic           w_is32;
    logic [2:0]     w_span;
    logic           w_inrange;
    logic           w_addr_ok;
    logic           w_last;
    logic [31:0]    w_val;
    logic [7:0]     w_byte;
    logic [7:0]     w_hdr;
    logic [AW-1:0]  w_base;

    assign w_is32    = i_cfg.entry_width_mode[1];
    assign w_span    = w_is32 ? 3'd4 : 3'd2;
    assign w_cur_inc = r_cur + 28'd1;
    assign w_base    = r_off[AW-1:0];
    assign w_last    = ({1'b0, r_bidx} == (w_span - 3'd1));
    assign w_val     = (r_op == OP_CONT) ? {4'd0, w_cur_inc} : 32'hFFFF_FFFF;
    assign w_inrange = (32'(r_off) + 32'(w_span)) <= 32'(TABLE_BYTES);
    assign w_addr_ok = 32'(r_addr) < 32'(TABLE_BYTES);

    // Byte offset of the current entry; twelve-bit entries sit at 3c/2.
    always_comb begin
        if (w_is32) begin
            w_off = {r_cur, 2'b00};
        end else if (i_cfg.entry_width_mode == MODE_16) begin
            w_off = OFF_W'({r_cur, 1'b0});
        end else begin
            w_off = OFF_W'(r_cur) + OFF_W'(r_cur[27:1]);
        end
    end

    // Byte to write for the current entry. A twelve-bit entry shares a nibble
    // with its neighbor, which is kept from the byte read back into r_old.
    always_comb begin
        if (i_cfg.entry_width_mode == MODE_12) begin
            if (r_odd) begin
                w_byte = (r_bidx == 2'd0) ? {w_val[3:0], r_old[3:0]} : w_val[11:4];
            end else begin
                w_byte = (r_bidx == 2'd0) ? w_val[7:0] : {r_old[7:4], w_val[11:8]};
            end
        end else begin
            case (r_bidx)
                2'd0:    w_byte = w_val[7:0];
                2'd1:    w_byte = w_val[15:8];
                2'd2:    w_byte = w_val[23:16];
                default: w_byte = w_val[31:24];
            endcase
        end
    end

    // Header bytes laid down by the init sweep.
    always_comb begin
        if (r_clr == AW'(0)) begin
            w_hdr = i_cfg.media_byte;
        end else if (r_clr == AW'(1) || r_clr == AW'(2)) begin
            w_hdr = 8'hFF;
        end else if (r_clr == AW'(3) && i_cfg.entry_width_mode != MODE_12) begin
            w_hdr = 8'hFF;
        end else begin
            w_hdr = 8'h00;
        end
    end

    // The read address serves the byte read and the twelve-bit merge read.
    always_comb begin
        if (r_op == OP_READ) begin
            o_mem_raddr = AW'(r_addr);
        end else if (r_odd) begin
            o_mem_raddr = w_base;
        end else begin
            o_mem_raddr = w_base + AW'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_clr       = r_clr;
        n_init      = r_init;
        n_bidx      = r_bidx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_clr;
        o_mem_wdata = 8'h00;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = r_init ? w_hdr : 8'h00;
                if (r_clr == CLR_LAST) begin
                    n_clr = '0;
                    if (r_init) begin
                        n_cur   = 28'd1;
                        n_init  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_res   = '0;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_bidx  = 2'd0;
                n_state = S_DONE;
                case (r_op)
                    OP_START: begin
                        if (r_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_cur                = w_cur_inc;
                            n_res.cluster_number = w_cur_inc;
                        end
                    end
                    OP_CONT: begin
                        if (r_full) begin
                            n_res.status = ST_FULL;
                        end else if (!w_inrange) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            n_state = (i_cfg.entry_width_mode == MODE_12) ? S_MERGE : S_WRITE;
                        end
                    end
                    OP_END: begin
                        if (!w_inrange) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            n_state = (i_cfg.entry_width_mode == MODE_12) ? S_MERGE : S_WRITE;
                        end
                    end
                    OP_READ: begin
                        if (w_addr_ok) begin
                            n_state = S_RDWAIT;
                        end else begin
                            n_res.status = ST_RANGE;
                        end
                    end
                    OP_INIT: begin
                        n_init  = 1'b1;
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RDWAIT: begin
                n_res.read_data = i_mem_rdata;
                n_state         = S_DONE;
            end
            S_MERGE: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = w_base + AW'(r_bidx);
                o_mem_wdata = w_byte;
                if (w_last) begin
                    if (r_op == OP_CONT) begin
                        n_cur                = w_cur_inc;
                        n_res.cluster_number = w_cur_inc;
                    end
                    n_state = S_DONE;
                end else begin
                    n_bidx = r_bidx + 2'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= 28'd1;
            r_clr       <= '0;
            r_init      <= 1'b0;
            r_bidx      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_clr       <= n_clr;
            r_init      <= n_init;
            r_bidx      <= n_bidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
        if (r_state == S_IDLE && i_in_valid) begin
            r_op   <= i_in_item.opcode;
            r_addr <= i_in_item.byte_address;
        end
        if (r_state == S_CALC) begin
            r_off  <= w_off;
            r_full <= ({1'b0, r_cur} + 29'd1) >= {1'b0, i_cfg.cluster_count};
            r_odd  <= r_cur[0];
        end
        if (r_state == S_MERGE) begin
            r_old <= i_mem_rdata;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- src/fat_cluster_chain_writer.sv -----
// ============================================================================
// fat_cluster_chain_writer - FAT allocation table builder
// Keeps a FAT12, FAT16 or FAT32 allocation table in a byte-wide RAM and hands
// out clusters in increasing order, writing chain links and end markers.
// ============================================================================
//
//   Channel   Direction  Handshake                   Payload
//   -------   ---------  --------------------------  -------------------------
//   in        input      i_in_valid / o_in_ready     i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_ready   o_out_item (t_out_item)
//   config    input      psel, penable, pwrite       paddr, pwdata / prdata
//
// After reset the table RAM is swept to zero, one byte per cycle; no item is
// taken during that pass, while configuration writes are taken as ever. An item
// is handled one at a time by a sequencer around the single table RAM: start
// checks and steps the counter, a byte read waits for the registered RAM data,
// continue and end write the entry's bytes in turn (2 or 4), after a read of
// the shared byte for a twelve-bit entry, and init sweeps the table again, laying
// down the header. The finished result sits in an output register, so the next
// item is taken while the previous result still waits for the consumer.
//
module fat_cluster_chain_writer #(
    parameter int unsigned TABLE_BYTES = fcw_pkg::FCW_TABLE_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fcw_pkg::t_in_item  i_in_item,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fcw_pkg::t_out_item o_out_item,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import fcw_pkg::*;

    // Byte address width of the table RAM.
    localparam int unsigned AW = $clog2(TABLE_BYTES);

    t_cfg          w_cfg;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]    w_mem_wdata;
    logic [AW-1:0] w_mem_raddr;
    logic [7:0]    w_mem_rdata;

    // Register file: entry width, cluster count and media byte.
    fcw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer: decodes items, owns the cluster counter and all RAM traffic.
    fcw_seq #(
        .TABLE_BYTES (TABLE_BYTES),
        .AW          (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // The allocation table itself, one byte per entry of the RAM.
    fcw_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_BYTES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

// ----- bench/tb.sv -----
// ============================================================================
// tb - self-checking bench for the FAT cluster chain writer
// Sends allocation, link, end-marker, byte-read and init requests through the
// valid/ready request channel. It tracks the allocation table in a
// scoreboard of its own and compares every result item field by field. The
// registers are set up over the APB port between phases, with the bench
// side idle.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcw_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int LONG_HOLD     = 400;
    localparam int TAIL_CYCLES   = 40;

    // Width codes the package leaves implicit: both upper codes decode as 32-bit.
    localparam logic [1:0] MODE_32     = 2'd2;
    localparam logic [1:0] MODE_32_ALT = 2'd3;

    // Opcodes with no function; the block must answer them with all zeros.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic [27:0] COUNT_MIN = 28'd2;
    localparam logic [27:0] COUNT_MAX = 28'hFFF_FFFF;
    localparam logic [12:0] ADDR_MAX  = 13'h1FFF;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the table, the allocation counter and the
    // registers. Every accepted request is played against this copy to get
    // its result item, which waits in a queue until the block answers.
    // ------------------------------------------------------------------------
    class fat_chain_scoreboard;
        logic [7:0]  fat_bytes [FCW_TABLE_BYTES];
        logic [27:0] alloc_cluster;
        logic [1:0]  width_mode;
        logic [27:0] total_clusters;
        logic [7:0]  media;
        t_out_item   pending_results [$];
        int unsigned error_count;

        function new();
            foreach (fat_bytes[i]) fat_bytes[i] = 8'h00;
            alloc_cluster  = 28'd1;
            width_mode     = MODE_RST;
            total_clusters = COUNT_RST;
            media          = MEDIA_RST;
            error_count    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MODE:  width_mode = value[1:0];
                REG_COUNT: total_clusters = value[27:0];
                REG_MEDIA: media = value[7:0];
                default: ;
            endcase
        endfunction

        function bit volume_full();
            return ({1'b0, alloc_cluster} + 29'd1) >= {1'b0, total_clusters};
        endfunction

        // Stores a value into the entry of the current cluster. Returns 0 and
        // leaves the table alone when the entry runs past the last byte.
        function bit write_entry(logic [31:0] value);
            longint unsigned c;
            longint unsigned offset;
            longint unsigned span;
            c = alloc_cluster;
            if (width_mode == MODE_12) begin
                span   = 2;
                offset = (3 * c) / 2;
            end else if (width_mode == MODE_16) begin
                span   = 2;
                offset = 2 * c;
            end else begin
                span   = 4;
                offset = 4 * c;
            end
            if (offset + span > FCW_TABLE_BYTES)
                return 1'b0;
            if (width_mode == MODE_12) begin
                // Odd clusters own the high nibble of their first byte, even
                // clusters the low nibble of their second byte.
                if (alloc_cluster[0]) begin
                    fat_bytes[offset]     = {value[3:0], fat_bytes[offset][3:0]};
                    fat_bytes[offset + 1] = value[11:4];
                end else begin
                    fat_bytes[offset]     = value[7:0];
                    fat_bytes[offset + 1] = {fat_bytes[offset + 1][7:4], value[11:8]};
                end
            end else begin
                for (int b = 0; b < span; b++)
                    fat_bytes[offset + b] = value[8*b +: 8];
            end
            return 1'b1;
        endfunction

        function void note_request(t_in_item item);
            t_out_item result;
            result = '0;
            case (item.opcode)
                OP_START: begin
                    if (volume_full()) begin
                        result.status = ST_FULL;
                    end else begin
                        alloc_cluster = alloc_cluster + 28'd1;
                        result.cluster_number = alloc_cluster;
                    end
                end
                OP_CONT: begin
                    if (volume_full()) begin
                        result.status = ST_FULL;
                    end else if (!write_entry({4'h0, alloc_cluster + 28'd1})) begin
                        result.status = ST_RANGE;
                    end else begin
                        alloc_cluster = alloc_cluster + 28'd1;
                        result.cluster_number = alloc_cluster;
                    end
                end
                OP_END: begin
                    if (!write_entry(32'hFFFF_FFFF))
                        result.status = ST_RANGE;
                end
                OP_READ: begin
                    if (item.byte_address < FCW_TABLE_BYTES)
                        result.read_data = fat_bytes[item.byte_address];
                    else
                        result.status = ST_RANGE;
                end
                OP_INIT: begin
                    foreach (fat_bytes[i]) fat_bytes[i] = 8'h00;
                    fat_bytes[0] = media;
                    fat_bytes[1] = 8'hFF;
                    fat_bytes[2] = 8'hFF;
                    if (width_mode != MODE_12)
                        fat_bytes[3] = 8'hFF;
                    alloc_cluster = 28'd1;
                end
                default: ;
            endcase
            pending_results.push_back(result);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item: cluster %0d data %02h status %0d",
                         $time, got.cluster_number, got.read_data, got.status);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.cluster_number !== want.cluster_number) begin
                $display("%0t: cluster_number expected %0d, got %0d",
                         $time, want.cluster_number, got.cluster_number);
                error_count++;
            end
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data expected %02h, got %02h",
                         $time, want.read_data, got.read_data);
                error_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d",
                         $time, want.status, got.status);
                error_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all at known values from time zero.
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    fat_chain_scoreboard sb;

    // Sender burst state: items left in the current burst.
    int burst_left = 0;

    // The main sequence asks for a long receiver hold by bumping the request
    // count; the receiver process serves each request once.
    int hold_requests = 0;
    int holds_served  = 0;
    int recv_hold_left  = 0;
    int recv_style      = 0;
    int recv_style_left = 0;
    int recv_tick       = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    fat_cluster_chain_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Monitor. Both handshakes are sampled at the rising edge, before any
    // nonblocking update of that edge lands. A request is noted before a
    // result of the same edge is checked. That result can only belong to
    // an older item, so the order is harmless.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_request(i_in_item);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_item);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It switches between three stall styles for random stretches:
    // always ready, coin-flip ready, and a fixed three-in-seven pattern. A
    // pending long-hold request overrides all of them. The hold is counted
    // here so that the sender keeps going and the block backs up into its
    // input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        recv_tick++;
        if (recv_hold_left > 0) begin
            recv_hold_left--;
            i_out_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            recv_hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            if (recv_style_left == 0) begin
                recv_style      = $urandom_range(0, 2);
                recv_style_left = $urandom_range(16, 160);
            end
            recv_style_left--;
            case (recv_style)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 99) < 55);
                default: i_out_ready <= ((recv_tick % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. Items go out in bursts of random length. Before each
    // burst there is usually a gap of a few idle cycles, so idle time falls
    // at every stage of the sequencer's work. The task returns at the edge
    // that accepted the item.
    // ------------------------------------------------------------------------
    task automatic offer_request(input logic [2:0] op, input logic [12:0] addr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= '{opcode: op, byte_address: addr};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops sending and waits until every expected result item has come back.
    // The first edge lets the monitor note an item taken at the current edge.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of one register, followed by a read back of the same register.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback_value;
        case (idx)
            REG_MODE:  readback_value = {30'd0, value[1:0]};
            REG_COUNT: readback_value = {4'd0, value[27:0]};
            default:   readback_value = {24'd0, value[7:0]};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== readback_value) begin
            $display("%0t: register %0d read back expected %08h, got %08h",
                     $time, idx, readback_value, prdata);
            sb.error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random traffic. Most of it is well-formed files: a start, a few links
    // and an end marker. Byte reads are aimed mostly at the low part of the
    // table, where the chains live. The rest is loose requests, such as
    // links and ends with no start, spare opcodes, and now and then an init.
    task automatic random_traffic(input int item_total);
        int sent;
        int roll;
        int links;
        logic [2:0] op;
        sent = 0;
        while (sent < item_total) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                links = $urandom_range(0, 6);
                offer_request(OP_START, 13'($urandom_range(0, ADDR_MAX)));
                repeat (links) offer_request(OP_CONT, 13'($urandom_range(0, ADDR_MAX)));
                offer_request(OP_END, 13'($urandom_range(0, ADDR_MAX)));
                sent += links + 2;
            end else if (roll < 85) begin
                if ($urandom_range(0, 3) != 0)
                    offer_request(OP_READ, 13'($urandom_range(0, 255)));
                else
                    offer_request(OP_READ, 13'($urandom_range(0, ADDR_MAX)));
                sent++;
            end else if (roll < 97) begin
                op = 3'($urandom_range(0, 7));
                if (op == OP_INIT)
                    op = OP_SPARE_HI;
                offer_request(op, 13'($urandom_range(0, ADDR_MAX)));
                if (op < OP_INIT)
                    sent++;
            end else begin
                offer_request(OP_INIT, 13'($urandom_range(0, ADDR_MAX)));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [1:0]  mode_pick;
        logic [27:0] count_pick;
        logic [7:0]  media_pick;

        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values. The block first acts on the
        // bare zero table, then on the table that init builds. The block's
        // clearing pass after reset simply holds off the first item.
        offer_request(OP_READ, 13'd0);
        offer_request(OP_READ, ADDR_MAX);
        offer_request(OP_START, ADDR_MAX);
        offer_request(OP_CONT, 13'h0AAA);
        offer_request(OP_END, 13'h1555);
        offer_request(OP_READ, 13'd4);
        offer_request(OP_READ, 13'd5);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            offer_request(3'(op), ADDR_MAX);
        offer_request(OP_INIT, 13'd0);
        for (int a = 0; a < 4; a++)
            offer_request(OP_READ, 13'(a));
        offer_request(OP_START, 13'd0);
        repeat (3) offer_request(OP_CONT, 13'd0);
        offer_request(OP_END, 13'd0);
        for (int a = 3; a < 10; a++)
            offer_request(OP_READ, 13'(a));
        wait_for_results();

        // Configuration phases. Every register sees both of its extremes.
        // One phase keeps the table and the counter from the phase before.
        for (int phase = 0; phase < 7; phase++) begin
            media_pick = 8'($urandom_range(0, 255));
            case (phase)
                0: begin
                    mode_pick = MODE_16;  count_pick = COUNT_MIN;  media_pick = 8'h00;
                end
                1: begin
                    mode_pick = MODE_32;  count_pick = COUNT_MAX;  media_pick = 8'hFF;
                end
                2: begin
                    mode_pick = MODE_12;  count_pick = 28'($urandom_range(20, 400));
                end
                3: begin
                    mode_pick = MODE_32_ALT;  count_pick = 28'($urandom_range(3, 40));
                end
                4: begin
                    mode_pick = MODE_12;  count_pick = COUNT_RST;
                end
                5: begin
                    mode_pick  = 2'($urandom_range(0, 3));
                    count_pick = 28'($urandom_range(2, 3000));
                end
                default: begin
                    mode_pick = MODE_16;  count_pick = 28'($urandom_range(2, 12));
                end
            endcase
            write_register(REG_MODE, {30'd0, mode_pick});
            write_register(REG_COUNT, {4'd0, count_pick});
            write_register(REG_MEDIA, {24'd0, media_pick});
            if (phase != 3)
                offer_request(OP_INIT, 13'($urandom_range(0, ADDR_MAX)));
            // One long receiver hold while the sender keeps offering items.
            if (phase == 2)
                hold_requests++;
            random_traffic(PHASE_ITEMS);
            wait_for_results();
        end

        // Every result is in. A short tail catches any stray result item.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run, including its inits.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
